>>> hdl/stl_pkg.sv
// stl_pkg: shared types and codes for the session table with login lockout
// holds the transaction payload structs, request/status codes, register indexes and fsm states
// no dependencies

package stl_pkg;

    localparam int SESSIONS_DEF     = 8;
    localparam int TOKEN_W          = 64;
    localparam int TIME_W           = 32;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 32;

    // reset values of the configuration registers
    localparam logic [7:0]        LOCK_FAIL_LIMIT_RST = 8'd5;
    localparam logic [TIME_W-1:0] LOCK_SECONDS_RST    = 32'd300;
    localparam logic [TIME_W-1:0] SESSION_SECONDS_RST = 32'd3600;

    typedef enum logic [1:0] {
        ACT_LOGIN  = 2'd0,
        ACT_CHECK  = 2'd1,
        ACT_LOGOUT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_REJECT = 2'd1,
        STS_LOCKED = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOCK_FAIL_LIMIT = 2'd0,
        REG_LOCK_SECONDS    = 2'd1,
        REG_SESSION_SECONDS = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [TIME_W-1:0]  now_seconds;
        logic               password_ok;
        logic               token_ok;
        logic [TOKEN_W-1:0] token_high;
        logic [TOKEN_W-1:0] token_low;
    } stl_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
    } stl_out_t;

    // one table entry as stored in memory: token then expiry
    typedef struct packed {
        logic [TOKEN_W-1:0] token_high;
        logic [TOKEN_W-1:0] token_low;
        logic [TIME_W-1:0]  expiry;
    } stl_entry_t;

endpackage

>>> hdl/stl_ram.sv
// stl_ram: generic single write port, single read port memory with registered read data
// no dependencies

module stl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/session_table_with_lockout_core.sv
// session_table_with_lockout_core: session token table with login lockout, top level
// depends on stl_pkg and stl_ram (token and expiry storage)
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-------------------------
//  request | s_valid s_ready s_data         | in        | stl_pkg::stl_in_t
//  result  | m_valid m_ready m_data         | out       | stl_pkg::stl_out_t
//  config  | cfg_valid cfg_ready cfg_index  | in        | cfg_data (32 bit)
//
// one request at a time: an unlocked login with a good password scans every slot through
// the registered memory read port and then writes the chosen slot, a check/logout with a
// well-formed token stops at the first match, and every other request goes from the decide
// step straight to the finish step.
// the result sits in an output register, so the next request is taken while it waits;
// the finish step stalls only while that register is still full and not being drained.
// reset (aresetn low, synchronous) empties the table through the per-slot used bits
// at once; no clearing pass. config writes are always taken (cfg_ready high).

module session_table_with_lockout_core #(
    parameter int SESSIONS = stl_pkg::SESSIONS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  stl_pkg::stl_in_t                      s_data,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output stl_pkg::stl_out_t                     m_data,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [stl_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [stl_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import stl_pkg::*;

    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int CW = $clog2(SESSIONS + 1);
    localparam int EW = $bits(stl_entry_t);
    localparam logic [IW-1:0] LAST_IDX = IW'(SESSIONS - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(SESSIONS);

    // control state
    state_t              state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    logic [SESSIONS-1:0] used_reg, used_next;
    logic [7:0]          fail_count_reg, fail_count_next;
    logic [TIME_W-1:0]   locked_until_reg, locked_until_next;
    logic [7:0]          lock_fail_limit_reg;
    logic [TIME_W-1:0]   lock_seconds_reg;
    logic [TIME_W-1:0]   session_seconds_reg;
    logic [CW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;

    // payload
    stl_in_t             item_reg;
    stl_out_t            m_data_reg, m_data_next;
    stl_out_t            res_reg, res_next;
    logic                find_mode_reg, find_mode_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]   best_exp_reg, best_exp_next;

    // memory port
    logic                ram_we;
    logic                ram_re;
    stl_entry_t          ram_wdata;
    logic [EW-1:0]       ram_rdata;
    stl_entry_t          rd_entry;
    logic [TIME_W-1:0]   eff_expiry;
    logic                tok_match;
    logic [7:0]          fail_inc;

    stl_ram #(
        .WIDTH (EW),
        .DEPTH (SESSIONS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (best_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_cnt_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry   = stl_entry_t'(ram_rdata);
    // an unused slot counts as expiry zero
    assign eff_expiry = used_reg[cmp_idx_reg] ? rd_entry.expiry : '0;
    assign tok_match  = used_reg[cmp_idx_reg]
                        && (rd_entry.token_high == item_reg.token_high)
                        && (rd_entry.token_low == item_reg.token_low);
    assign fail_inc   = (fail_count_reg == 8'hFF) ? fail_count_reg : fail_count_reg + 8'd1;

    assign ram_wdata.token_high = item_reg.token_high;
    assign ram_wdata.token_low  = item_reg.token_low;
    assign ram_wdata.expiry     = item_reg.now_seconds + session_seconds_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            m_valid_reg         <= 1'b0;
            used_reg            <= '0;
            fail_count_reg      <= '0;
            locked_until_reg    <= '0;
            lock_fail_limit_reg <= LOCK_FAIL_LIMIT_RST;
            lock_seconds_reg    <= LOCK_SECONDS_RST;
            session_seconds_reg <= SESSION_SECONDS_RST;
            rd_cnt_reg          <= '0;
            cmp_vld_reg         <= 1'b0;
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            used_reg         <= used_next;
            fail_count_reg   <= fail_count_next;
            locked_until_reg <= locked_until_next;
            rd_cnt_reg       <= rd_cnt_next;
            cmp_vld_reg      <= cmp_vld_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_LOCK_FAIL_LIMIT: lock_fail_limit_reg <= cfg_data[7:0];
                    REG_LOCK_SECONDS:    lock_seconds_reg    <= cfg_data;
                    REG_SESSION_SECONDS: session_seconds_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        m_data_reg    <= m_data_next;
        res_reg       <= res_next;
        find_mode_reg <= find_mode_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_exp_reg  <= best_exp_next;
    end

    always_comb begin
        state_next        = state_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        res_next          = res_reg;
        used_next         = used_reg;
        fail_count_next   = fail_count_reg;
        locked_until_next = locked_until_reg;
        rd_cnt_next       = rd_cnt_reg;
        find_mode_next    = find_mode_reg;
        best_idx_next     = best_idx_reg;
        best_exp_next     = best_exp_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_next.status = STS_REJECT;
                res_next.slot   = '0;
                rd_cnt_next     = '0;
                state_next      = ST_FINISH;
                unique case (item_reg.action) inside
                    ACT_LOGIN: begin
                        if (item_reg.now_seconds < locked_until_reg) begin
                            res_next.status = STS_LOCKED;
                        end else if (!item_reg.password_ok) begin
                            fail_count_next = fail_inc;
                            if (fail_inc >= lock_fail_limit_reg) begin
                                locked_until_next = item_reg.now_seconds + lock_seconds_reg;
                            end
                        end else begin
                            find_mode_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                    end
                    ACT_CHECK, ACT_LOGOUT: begin
                        if (item_reg.token_ok) begin
                            find_mode_next = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                // issue one read per cycle, evaluate the slot read the cycle before
                if (rd_cnt_reg != CNT_END) begin
                    ram_re      = 1'b1;
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
                if (cmp_vld_reg) begin
                    if (find_mode_reg) begin
                        if (tok_match) begin
                            state_next = ST_FINISH;
                            if (item_reg.action == ACT_CHECK) begin
                                res_next.status = (item_reg.now_seconds < rd_entry.expiry)
                                                  ? STS_OK : STS_REJECT;
                            end else begin
                                used_next[cmp_idx_reg] = 1'b0;
                                res_next.status        = STS_OK;
                            end
                        end else if (cmp_idx_reg == LAST_IDX) begin
                            state_next = ST_FINISH;
                        end
                    end else begin
                        if (cmp_idx_reg == '0 || eff_expiry < best_exp_reg) begin
                            best_idx_next = cmp_idx_reg;
                            best_exp_next = eff_expiry;
                        end
                        if (cmp_idx_reg == LAST_IDX) begin
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_WRITE: begin
                ram_we                  = 1'b1;
                used_next[best_idx_reg] = 1'b1;
                fail_count_next         = '0;
                res_next.status         = STS_OK;
                res_next.slot           = 3'(best_idx_reg);
                state_next              = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        cmp_vld_next = ram_re;
        cmp_idx_next = rd_cnt_reg[IW-1:0];
    end

    // one request in flight at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in progress");

    // a table write always leaves its slot marked used
    a_write_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> used_reg[$past(best_idx_reg)])
        else $error("written slot not marked used");

    // the lockout time only moves when a login is decided
    a_lock_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DECIDE) |=> $stable(locked_until_reg))
        else $error("lockout time changed outside login decision");

    // a result is only loaded from the finish step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside finish step");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for session_table_with_lockout_core
// predicts every result from its own session table and lockout state and checks each transaction
// depends on stl_pkg and the core rtl
`timescale 1ns / 100ps

module tb_top;
    import stl_pkg::*;

    localparam int          SESSIONS       = SESSIONS_DEF;
    localparam logic [1:0]  ACT_UNKNOWN    = 2'd3;
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          PHASE_ITEMS    = 90;
    localparam logic [127:0] TOKEN_A = 128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210;
    localparam logic [127:0] TOKEN_B = 128'h8000_0000_0000_0001_7FFF_FFFF_FFFF_FFFE;
    localparam logic [127:0] TOKEN_C = 128'h5555_AAAA_5555_AAAA_AAAA_5555_AAAA_5555;
    localparam logic [127:0] TOKEN_D = 128'hDEAD_0000_BEEF_0000_0000_CAFE_0000_F00D;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    stl_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    stl_out_t  m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predicted block state
    logic [TOKEN_W-1:0] sess_hi     [SESSIONS];
    logic [TOKEN_W-1:0] sess_lo     [SESSIONS];
    logic [TIME_W-1:0]  sess_expiry [SESSIONS];
    logic               sess_live   [SESSIONS];
    logic [7:0]         fail_run;
    logic [TIME_W-1:0]  lockout_end;
    logic [7:0]         lim_failures;
    logic [TIME_W-1:0]  lockout_len;
    logic [TIME_W-1:0]  session_len;

    stl_out_t     expected_results[$];
    logic [127:0] recent_tokens[$];
    logic [TIME_W-1:0] clock_now;
    int  mismatch_count  = 0;
    int  requests_seen   = 0;
    int  logins_granted  = 0;
    int  lockouts_seen   = 0;
    int  sessions_valid  = 0;
    int  quiet_cycles    = 0;
    int  hold_request    = 0;
    bit  idling          = 1'b1;

    session_table_with_lockout_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int i = 0; i < SESSIONS; i++) begin
            sess_hi[i]     = '0;
            sess_lo[i]     = '0;
            sess_expiry[i] = '0;
            sess_live[i]   = 1'b0;
        end
        fail_run     = '0;
        lockout_end  = '0;
        lim_failures = LOCK_FAIL_LIMIT_RST;
        lockout_len  = LOCK_SECONDS_RST;
        session_len  = SESSION_SECONDS_RST;
        clock_now    = '0;
    end

    // advances the session table and lockout state by one request
    function automatic stl_out_t predict_session(stl_in_t req);
        stl_out_t res;
        int       best;
        int       hit;
        res.status = STS_REJECT;
        res.slot   = '0;
        hit        = SESSIONS;
        if (req.action != ACT_LOGIN && req.token_ok) begin
            for (int i = SESSIONS - 1; i >= 0; i--)
                if (sess_live[i] && sess_hi[i] == req.token_high
                    && sess_lo[i] == req.token_low)
                    hit = i;
        end
        case (req.action)
            ACT_LOGIN: begin
                if (req.now_seconds < lockout_end) begin
                    res.status = STS_LOCKED;
                    lockouts_seen++;
                end else if (!req.password_ok) begin
                    if (fail_run != 8'hFF)
                        fail_run++;
                    if (fail_run >= lim_failures)
                        lockout_end = req.now_seconds + lockout_len;
                end else begin
                    best = 0;
                    fail_run = '0;
                    for (int i = 1; i < SESSIONS; i++)
                        if (sess_expiry[i] < sess_expiry[best])
                            best = i;
                    sess_hi[best]     = req.token_high;
                    sess_lo[best]     = req.token_low;
                    sess_expiry[best] = req.now_seconds + session_len;
                    sess_live[best]   = 1'b1;
                    res.status = STS_OK;
                    res.slot   = best[2:0];
                    logins_granted++;
                end
            end
            ACT_CHECK: begin
                if (hit < SESSIONS && req.now_seconds < sess_expiry[hit]) begin
                    res.status = STS_OK;
                    sessions_valid++;
                end
            end
            ACT_LOGOUT: begin
                if (hit < SESSIONS) begin
                    sess_hi[hit]     = '0;
                    sess_lo[hit]     = '0;
                    sess_expiry[hit] = '0;
                    sess_live[hit]   = 1'b0;
                    res.status = STS_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // result checker, register shadow, request predictor and watchdog
    always @(posedge aclk) begin
        stl_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d slot %0d", m_data.status, m_data.slot);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_data.status);
                        mismatch_count++;
                    end
                    if (m_data.slot !== want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, m_data.slot);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LOCK_FAIL_LIMIT: lim_failures = cfg_data[7:0];
                    REG_LOCK_SECONDS:    lockout_len  = cfg_data;
                    REG_SESSION_SECONDS: session_len  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_session(s_data));
                requests_seen++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no transaction for %0d cycles, %0d results pending",
                             quiet_cycles, expected_results.size());
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // result side: random stalls per result while idling is set, plus a long hold when requested
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            stall = idling ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [TIME_W-1:0] now,
                                input logic pw, input logic tok_ok, input logic [127:0] token);
        stl_in_t req;
        int      gap;
        req.action      = act;
        req.now_seconds = now;
        req.password_ok = pw;
        req.token_ok    = tok_ok;
        req.token_high  = token[127:64];
        req.token_low   = token[63:0];
        gap = idling ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] limit, input logic [TIME_W-1:0] lock_secs,
                             input logic [TIME_W-1:0] sess_secs);
        logic [CFG_DATA_W-1:0] limit_word;
        wait_for_results();
        // upper bits of the limit write carry noise, only the low byte counts
        limit_word = {$urandom} & 32'hFFFF_FF00 | limit;
        cfg_valid <= 1'b1;
        cfg_index <= REG_LOCK_FAIL_LIMIT;
        cfg_data  <= limit_word;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_LOCK_SECONDS;
        cfg_data  <= lock_secs;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_SESSION_SECONDS;
        cfg_data  <= sess_secs;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void advance_clock();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 82)
            clock_now += $urandom_range(0, 150);
        else if (r < 90)
            clock_now = $urandom;
        else if (r < 95)
            clock_now = 32'hFFFF_FFFF - $urandom_range(0, 400);
        else
            clock_now += $urandom_range(0, 5000);
    endfunction

    // mostly plausible traffic: tokens that were issued, a few foreign or malformed ones
    task automatic send_random_request(input int pw_bias);
        int           pick;
        int           k;
        logic [1:0]   act;
        logic         pw;
        logic         tok_ok;
        logic [127:0] token;
        advance_clock();
        pick   = $urandom_range(0, 99);
        pw     = ($urandom_range(0, 99) < pw_bias);
        tok_ok = ($urandom_range(0, 9) != 0);
        token  = {$urandom, $urandom, $urandom, $urandom};
        if (pick < 40) begin
            act = ACT_LOGIN;
            // reuse a recent token now and then so duplicate entries appear
            if (recent_tokens.size() > 0 && $urandom_range(0, 9) == 0)
                token = recent_tokens[$urandom_range(0, recent_tokens.size() - 1)];
            if (pw) begin
                recent_tokens.push_back(token);
                if (recent_tokens.size() > 16)
                    void'(recent_tokens.pop_front());
            end
        end else if (pick < 95) begin
            act = (pick < 72) ? ACT_CHECK : ACT_LOGOUT;
            k = $urandom_range(0, 9);
            if (k < 6) begin
                k = $urandom_range(0, SESSIONS - 1);
                token = {sess_hi[k], sess_lo[k]};
            end else if (k < 8 && recent_tokens.size() > 0) begin
                token = recent_tokens[$urandom_range(0, recent_tokens.size() - 1)];
            end else if (k == 8) begin
                token = '0;
            end
        end else begin
            act = ACT_UNKNOWN;
        end
        send_request(act, clock_now, pw, tok_ok, token);
    endtask

    task automatic test_directed_basics();
        send_request(ACT_CHECK,  32'd0, 1'b1, 1'b0, '0);
        send_request(ACT_CHECK,  32'd0, 1'b0, 1'b1, '0);
        send_request(ACT_LOGOUT, 32'd0, 1'b0, 1'b1, '0);
        send_request(ACT_LOGIN,  32'd1000, 1'b1, 1'b0, TOKEN_A);
        send_request(ACT_CHECK,  32'd1000, 1'b0, 1'b1, TOKEN_A);
        send_request(ACT_CHECK,  32'd4599, 1'b0, 1'b1, TOKEN_A);
        send_request(ACT_CHECK,  32'd4600, 1'b0, 1'b1, TOKEN_A);
        send_request(ACT_CHECK,  32'd4000, 1'b1, 1'b0, TOKEN_A);
        send_request(ACT_UNKNOWN, 32'd4000, 1'b1, 1'b1, TOKEN_A);
        // five failures reach the default limit
        for (int i = 0; i < 5; i++)
            send_request(ACT_LOGIN, 32'd2000 + i, 1'b0, 1'b1, TOKEN_C);
        send_request(ACT_LOGIN,  32'd2303, 1'b1, 1'b0, TOKEN_C);
        send_request(ACT_LOGIN,  32'd2304, 1'b0, 1'b0, TOKEN_C);
        send_request(ACT_LOGIN,  32'd2604, 1'b1, 1'b0, '1);
        send_request(ACT_LOGOUT, 32'd3000, 1'b1, 1'b0, TOKEN_A);
        send_request(ACT_LOGOUT, 32'd3000, 1'b0, 1'b1, TOKEN_A);
        send_request(ACT_CHECK,  32'd3000, 1'b0, 1'b1, TOKEN_A);
        send_request(ACT_LOGOUT, 32'd3000, 1'b0, 1'b1, TOKEN_A);
        // expiry wraps past the top of the time range
        send_request(ACT_LOGIN,  32'hFFFF_FF00, 1'b1, 1'b1, TOKEN_B);
        send_request(ACT_CHECK,  32'hFFFF_FF00, 1'b0, 1'b1, TOKEN_B);
        send_request(ACT_CHECK,  32'd100, 1'b0, 1'b1, TOKEN_B);
        send_request(ACT_LOGIN,  32'd5, 1'b1, 1'b0, '0);
        send_request(ACT_CHECK,  32'd6, 1'b0, 1'b1, '0);
        send_request(ACT_CHECK,  32'hFFFF_FFFF, 1'b0, 1'b1, '1);
    endtask

    task automatic test_lockout_edges();
        // zero limit locks on any failure; maximum lock length wraps to one second short
        configure(8'd0, 32'hFFFF_FFFF, SESSION_SECONDS_RST);
        send_request(ACT_LOGIN, 32'd10, 1'b0, 1'b0, TOKEN_C);
        send_request(ACT_LOGIN, 32'd10, 1'b1, 1'b0, TOKEN_C);
        send_request(ACT_LOGIN, 32'd20, 1'b0, 1'b0, TOKEN_C);
        send_request(ACT_LOGIN, 32'd18, 1'b1, 1'b0, TOKEN_C);
        configure(8'd1, 32'd50, SESSION_SECONDS_RST);
        send_request(ACT_LOGIN, 32'd100, 1'b0, 1'b0, TOKEN_D);
        send_request(ACT_LOGIN, 32'd149, 1'b1, 1'b0, TOKEN_D);
        send_request(ACT_LOGIN, 32'd149, 1'b0, 1'b0, TOKEN_D);
        send_request(ACT_LOGIN, 32'd150, 1'b1, 1'b0, TOKEN_D);
        // zero lock length never blocks, so the failure count can saturate
        configure(8'd255, 32'd0, SESSION_SECONDS_RST);
        for (int i = 0; i < 260; i++)
            send_request(ACT_LOGIN, 32'd1000 + i, 1'b0, 1'($urandom_range(0, 1)), TOKEN_D);
        configure(8'd255, 32'd1000, SESSION_SECONDS_RST);
        send_request(ACT_LOGIN, 32'd5000, 1'b0, 1'b0, TOKEN_D);
        send_request(ACT_LOGIN, 32'd5999, 1'b1, 1'b0, TOKEN_D);
        send_request(ACT_LOGIN, 32'd6000, 1'b1, 1'b0, TOKEN_D);
    endtask

    task automatic test_session_lifetime();
        configure(LOCK_FAIL_LIMIT_RST, LOCK_SECONDS_RST, 32'd1);
        send_request(ACT_LOGIN, 32'd500, 1'b1, 1'b0, TOKEN_C);
        send_request(ACT_CHECK, 32'd500, 1'b0, 1'b1, TOKEN_C);
        send_request(ACT_CHECK, 32'd501, 1'b0, 1'b1, TOKEN_C);
        configure(LOCK_FAIL_LIMIT_RST, LOCK_SECONDS_RST, 32'hFFFF_FFFF);
        send_request(ACT_LOGIN,  32'd7, 1'b1, 1'b0, TOKEN_D);
        send_request(ACT_CHECK,  32'd5, 1'b0, 1'b1, TOKEN_D);
        send_request(ACT_CHECK,  32'd7, 1'b0, 1'b1, TOKEN_D);
        send_request(ACT_LOGOUT, 32'd7, 1'b0, 1'b1, TOKEN_C);
        send_request(ACT_LOGOUT, 32'd7, 1'b0, 1'b1, TOKEN_D);
    endtask

    // result side holds off while requests keep coming, so the core must stall its input
    task automatic test_backpressure();
        configure(LOCK_FAIL_LIMIT_RST, LOCK_SECONDS_RST, SESSION_SECONDS_RST);
        idling = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_random_request(80);
        wait_for_results();
        idling = 1'b1;
    endtask

    task automatic run_traffic_phase(input logic [7:0] limit,
                                     input logic [TIME_W-1:0] lock_secs,
                                     input logic [TIME_W-1:0] sess_secs, input int pw_bias,
                                     input bit with_idle, input int count);
        configure(limit, lock_secs, sess_secs);
        idling = with_idle;
        for (int i = 0; i < count; i++)
            send_random_request(pw_bias);
        wait_for_results();
        idling = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(LOCK_FAIL_LIMIT_RST, LOCK_SECONDS_RST, SESSION_SECONDS_RST,
                          70, 1'b1, PHASE_ITEMS);
        run_traffic_phase(8'd1, 32'd0, 32'd1, 50, 1'b1, PHASE_ITEMS);
        run_traffic_phase(8'd3, $urandom_range(10, 2000), $urandom_range(100, 5000),
                          60, 1'b0, PHASE_ITEMS);
        run_traffic_phase(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40, 1'b1, PHASE_ITEMS);
        run_traffic_phase(8'($urandom_range(1, 255)), $urandom, $urandom_range(50, 1000),
                          70, 1'b1, PHASE_ITEMS);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_basics();
        test_lockout_edges();
        test_session_lifetime();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        $display("covered %0d requests: %0d logins granted, %0d refused by lockout, %0d %s",
                 requests_seen, logins_granted, lockouts_seen, sessions_valid,
                 "live session checks");
        $display("%s %s", "fail limits 0 to 255, lock and session lengths up to the full",
                 "time range, long output stall");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/stl_pkg.sv
hdl/stl_ram.sv
hdl/session_table_with_lockout_core.sv
tb/tb_top.sv
